/* hdl/gf128_pkg.sv */
// Shared types and constants for the GF(2^128) multiply / power / inverse unit.
package gf128_pkg;

	localparam int FIELD_BITS = 128;
	localparam logic [FIELD_BITS-1:0] RED_POLY = 128'h87;
	localparam logic [FIELD_BITS-1:0] FIELD_ONE = 128'h1;
	localparam logic [FIELD_BITS-1:0] INV_EXP = {{(FIELD_BITS-1){1'b1}}, 1'b0};

	localparam logic [1:0] ACT_MUL = 2'd0;
	localparam logic [1:0] ACT_POW = 2'd1;
	localparam logic [1:0] ACT_INV = 2'd2;

	typedef struct packed {
		logic [1:0]  action;
		logic [63:0] first_high;
		logic [63:0] first_low;
		logic [63:0] second_high;
		logic [63:0] second_low;
		logic [63:0] exponent;
	} req_item_t;

	typedef struct packed {
		logic [63:0] result_high;
		logic [63:0] result_low;
		logic        error;
	} rsp_item_t;

	typedef struct packed {
		logic                  start;
		logic [FIELD_BITS-1:0] a;
		logic [FIELD_BITS-1:0] b;
	} mul_req_t;

	typedef struct packed {
		logic                  busy;
		logic                  done;
		logic [FIELD_BITS-1:0] product;
	} mul_rsp_t;

endpackage

/* hdl/gf128_mul_unit.sv */
// Digit-serial GF(2^128) multiplier, DIGIT_BITS bits of the second operand per cycle.
module gf128_mul_unit #(
	parameter int DIGIT_BITS = 8
) (
	input  logic               clk,
	input  logic               arst_n,
	input  gf128_pkg::mul_req_t req,
	output gf128_pkg::mul_rsp_t rsp
);
	localparam int NSTEP = gf128_pkg::FIELD_BITS / DIGIT_BITS;
	localparam int CW = $clog2(NSTEP);
	localparam logic [CW-1:0] LAST = CW'(NSTEP - 1);

	logic                            busy_q;
	logic                            done_q;
	logic [CW-1:0]                   cnt_q;
	logic [gf128_pkg::FIELD_BITS-1:0] z_q, v_q, b_q;
	logic [gf128_pkg::FIELD_BITS-1:0] z_n, v_n;

	always_comb begin
		z_n = z_q;
		v_n = v_q;
		for (int i = 0; i < DIGIT_BITS; i++) begin
			if (b_q[i]) begin
				z_n = z_n ^ v_n;
			end
			v_n = {v_n[gf128_pkg::FIELD_BITS-2:0], 1'b0}
				^ (v_n[gf128_pkg::FIELD_BITS-1] ? gf128_pkg::RED_POLY : '0);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (req.start) begin
				busy_q <= 1'b1;
				cnt_q  <= '0;
			end else if (busy_q) begin
				cnt_q <= cnt_q + CW'(1);
				if (cnt_q == LAST) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (req.start) begin
			z_q <= '0;
			v_q <= req.a;
			b_q <= req.b;
		end else if (busy_q) begin
			z_q <= z_n;
			v_q <= v_n;
			b_q <= b_q >> DIGIT_BITS;
		end
	end

	assign rsp.busy    = busy_q;
	assign rsp.done    = done_q;
	assign rsp.product = z_q;
endmodule

/* hdl/gf2_128_mul_pow_inv_top.sv */
// Top level: GF(2^128) multiply, power and inverse around one shared multiplier.
// One field multiplication occupies the multiplier from its start until its done strobe.
// Multiply: the product is taken in S_MULT, then registered as the result in S_FIN.
// Power: up to 127 multiplications; inverse: 254.
// One item at a time; req_stall is high after accept until the result is registered.
// Reset clears the sequencer, the multiplier control and the output valid.
module gf2_128_mul_pow_inv_top #(
	parameter int DIGIT_BITS = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 req_valid,
	output logic                 req_stall,
	input  gf128_pkg::req_item_t req,
	output logic                 rsp_valid,
	input  logic                 rsp_stall,
	output gf128_pkg::rsp_item_t rsp
);
	typedef enum logic [5:0] {
		S_IDLE = 6'b000001,
		S_MULT = 6'b000010,
		S_STEP = 6'b000100,
		S_WS   = 6'b001000,
		S_WP   = 6'b010000,
		S_FIN  = 6'b100000
	} state_t;

	state_t                           state_q;
	logic [gf128_pkg::FIELD_BITS-1:0] s_q, p_q, e_q;
	logic                             err_q;
	logic                             rsp_valid_q;
	gf128_pkg::rsp_item_t             rsp_q;
	gf128_pkg::mul_req_t              mul_req;
	gf128_pkg::mul_rsp_t              mul_rsp;
	logic                             accept;
	logic [gf128_pkg::FIELD_BITS-1:0] first_op;
	logic                             first_zero;
	logic                             out_free;

	assign accept     = req_valid && !req_stall;
	assign req_stall  = (state_q != S_IDLE);
	assign first_op   = {req.first_high, req.first_low};
	assign first_zero = (first_op == '0);
	assign out_free   = !rsp_valid_q || !rsp_stall;

	always_comb begin
		mul_req.start = 1'b0;
		mul_req.a     = p_q;
		mul_req.b     = p_q;
		case (state_q)
			S_IDLE: begin
				mul_req.start = accept && (req.action == gf128_pkg::ACT_MUL);
				mul_req.a     = first_op;
				mul_req.b     = {req.second_high, req.second_low};
			end
			S_STEP: begin
				mul_req.start = 1'b1;
				mul_req.a     = e_q[0] ? s_q : p_q;
			end
			S_WS: begin
				mul_req.start = mul_rsp.done && (e_q[gf128_pkg::FIELD_BITS-1:1] != '0);
			end
			default: begin
				mul_req.start = 1'b0;
			end
		endcase
	end

	gf128_mul_unit #(
		.DIGIT_BITS(DIGIT_BITS)
	) u_mul (
		.clk   (clk),
		.arst_n(arst_n),
		.req   (mul_req),
		.rsp   (mul_rsp)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						if (req.action == gf128_pkg::ACT_MUL) begin
							state_q <= S_MULT;
						end else if ((req.action == gf128_pkg::ACT_POW && !first_zero
								&& req.exponent != '0)
								|| (req.action == gf128_pkg::ACT_INV && !first_zero)) begin
							state_q <= S_STEP;
						end else begin
							state_q <= S_FIN;
						end
					end
				end
				S_MULT: begin
					if (mul_rsp.done) begin
						state_q <= S_FIN;
					end
				end
				S_STEP: begin
					state_q <= e_q[0] ? S_WS : S_WP;
				end
				S_WS: begin
					if (mul_rsp.done) begin
						state_q <= (e_q[gf128_pkg::FIELD_BITS-1:1] != '0) ? S_WP : S_FIN;
					end
				end
				S_WP: begin
					if (mul_rsp.done) begin
						state_q <= S_STEP;
					end
				end
				S_FIN: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rsp_valid_q <= 1'b0;
		end else if (state_q == S_FIN && out_free) begin
			rsp_valid_q <= 1'b1;
		end else if (!rsp_stall) begin
			rsp_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					p_q   <= first_op;
					err_q <= (req.action == gf128_pkg::ACT_INV) && first_zero;
					e_q   <= (req.action == gf128_pkg::ACT_INV) ? gf128_pkg::INV_EXP
						: {{(gf128_pkg::FIELD_BITS-64){1'b0}}, req.exponent};
					if (req.action == gf128_pkg::ACT_POW && !first_zero) begin
						s_q <= gf128_pkg::FIELD_ONE;
					end else if (req.action == gf128_pkg::ACT_INV && !first_zero) begin
						s_q <= gf128_pkg::FIELD_ONE;
					end else begin
						s_q <= '0;
					end
				end
			end
			S_MULT, S_WS: begin
				if (mul_rsp.done) begin
					s_q <= mul_rsp.product;
				end
			end
			S_WP: begin
				if (mul_rsp.done) begin
					p_q <= mul_rsp.product;
					e_q <= e_q >> 1;
				end
			end
			S_FIN: begin
				if (out_free) begin
					rsp_q.result_high <= s_q[gf128_pkg::FIELD_BITS-1:64];
					rsp_q.result_low  <= s_q[63:0];
					rsp_q.error       <= err_q;
				end
			end
			default: begin
				s_q <= s_q;
			end
		endcase
	end

	assign rsp_valid = rsp_valid_q;
	assign rsp       = rsp_q;

	// multiplier is only started when free
	a_start_idle: assert property (@(posedge clk) disable iff (!arst_n)
		mul_req.start |-> !mul_rsp.busy)
		else $error("multiplier started while busy");

	// a finished multiplication always has a waiting sequencer state
	a_done_owner: assert property (@(posedge clk) disable iff (!arst_n)
		mul_rsp.done |-> (state_q == S_MULT || state_q == S_WS || state_q == S_WP))
		else $error("multiplier result dropped");

	// error is only raised with a zero result
	a_err_zero: assert property (@(posedge clk) disable iff (!arst_n)
		(rsp_valid && rsp.error) |-> (rsp.result_high == '0 && rsp.result_low == '0))
		else $error("error item with nonzero result");
endmodule
